### hdl/per_path_delta_filter_assert.svh
// Assertion macros shared by the filter RTL.
`ifndef PER_PATH_DELTA_FILTER_ASSERT_SVH
`define PER_PATH_DELTA_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define AST_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("filter assertion failed");
`define AST_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("filter assertion failed");
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("filter assertion failed");
`else
`define AST_NEVER(lbl, clk, rstn, expr)
`define AST_IMPL(lbl, clk, rstn, ante, cons)
`define AST_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hdl/ppdf_pkg.sv
`timescale 1ns / 1ps
package ppdf_pkg;
    localparam logic [1:0] TIER_FULL = 2'd0;
    localparam logic [1:0] TIER_RATE = 2'd1;
    localparam logic [1:0] TIER_CHG  = 2'd2;
    localparam logic [1:0] TIER_META = 2'd3;

    localparam logic [1:0] CFG_TIER = 2'd0;
    localparam logic [1:0] CFG_MAXU = 2'd1;
    localparam logic [1:0] CFG_MINC = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;

    localparam logic [31:0] WINDOW_MS = 32'd1000;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_SRD, S_SCMP, S_ERD, S_EACT, S_CRD, S_CCMP, S_YRD, S_YWR
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_SRCH_RD, OP_SRCH_NEXT, OP_HIT, OP_ALLOC, OP_ENT_RD,
        OP_SET_PEND, OP_RATE, OP_QCLR, OP_CMP_INIT, OP_CMP_RD, OP_CMP_STEP,
        OP_CPY_INIT, OP_CPY_RD, OP_CPY_WR, OP_SAVE_LEN
    } t_op;

    typedef enum logic [2:0] {
        RES_FWD, RES_DROP, RES_FULL, RES_LONG, RES_QUERY, RES_QZERO, RES_RATE
    } t_res;

    typedef struct packed {
        t_op  op;
        logic emit;
        t_res res;
    } t_ctl;

    typedef struct packed {
        logic       acc_end;
        logic       is_q;
        logic [1:0] tier;
        logic       too_long;
        logic       idx_end;
        logic       full;
        logic       key_hit;
        logic       old_zero;
        logic       cmp_end;
        logic       thresh_ok;
        logic       cpy_end;
    } t_sts;
endpackage

### hdl/ppdf_ctrl.sv
`timescale 1ns / 1ps
`include "per_path_delta_filter_assert.svh"
module ppdf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ppdf_pkg::t_sts  i_sts,
    output ppdf_pkg::t_ctl  o_ctl,
    output logic            o_busy
);
    import ppdf_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '{op: OP_NONE, emit: 1'b0, res: RES_DROP};
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.op = OP_ACCEPT;
                    if (i_sts.acc_end) n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.is_q) begin
                    if (i_sts.tier != TIER_META) begin
                        o_ctl.emit = 1'b1;
                        o_ctl.res  = RES_QZERO;
                        n_state    = S_IDLE;
                    end else begin
                        n_state = S_SRD;
                    end
                end else if (i_sts.tier == TIER_FULL) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.res  = RES_FWD;
                    n_state    = S_IDLE;
                end else if (i_sts.tier == TIER_CHG && i_sts.too_long) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.res  = RES_LONG;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                if (i_sts.idx_end) begin
                    if (i_sts.is_q) begin
                        o_ctl.emit = 1'b1;
                        o_ctl.res  = RES_QZERO;
                        n_state    = S_IDLE;
                    end else if (i_sts.full) begin
                        o_ctl.emit = 1'b1;
                        o_ctl.res  = RES_FULL;
                        n_state    = S_IDLE;
                    end else begin
                        o_ctl.op = OP_ALLOC;
                        n_state  = S_ERD;
                    end
                end else begin
                    o_ctl.op = OP_SRCH_RD;
                    n_state  = S_SCMP;
                end
            end
            S_SCMP: begin
                if (i_sts.key_hit) begin
                    o_ctl.op = OP_HIT;
                    n_state  = S_ERD;
                end else begin
                    o_ctl.op = OP_SRCH_NEXT;
                    n_state  = S_SRD;
                end
            end
            S_ERD: begin
                o_ctl.op = OP_ENT_RD;
                n_state  = S_EACT;
            end
            S_EACT: begin
                if (i_sts.is_q) begin
                    o_ctl.op   = OP_QCLR;
                    o_ctl.emit = 1'b1;
                    o_ctl.res  = RES_QUERY;
                    n_state    = S_IDLE;
                end else if (i_sts.tier == TIER_RATE) begin
                    o_ctl.op   = OP_RATE;
                    o_ctl.emit = 1'b1;
                    o_ctl.res  = RES_RATE;
                    n_state    = S_IDLE;
                end else if (i_sts.tier == TIER_META) begin
                    o_ctl.op   = OP_SET_PEND;
                    o_ctl.emit = 1'b1;
                    o_ctl.res  = RES_DROP;
                    n_state    = S_IDLE;
                end else if (i_sts.old_zero) begin
                    o_ctl.op = OP_CPY_INIT;
                    n_state  = S_YRD;
                end else begin
                    o_ctl.op = OP_CMP_INIT;
                    n_state  = S_CRD;
                end
            end
            S_CRD: begin
                if (i_sts.cmp_end) begin
                    if (i_sts.thresh_ok) begin
                        o_ctl.op = OP_CPY_INIT;
                        n_state  = S_YRD;
                    end else begin
                        o_ctl.emit = 1'b1;
                        o_ctl.res  = RES_DROP;
                        n_state    = S_IDLE;
                    end
                end else begin
                    o_ctl.op = OP_CMP_RD;
                    n_state  = S_CCMP;
                end
            end
            S_CCMP: begin
                o_ctl.op = OP_CMP_STEP;
                n_state  = S_CRD;
            end
            S_YRD: begin
                if (i_sts.cpy_end) begin
                    o_ctl.op   = OP_SAVE_LEN;
                    o_ctl.emit = 1'b1;
                    o_ctl.res  = RES_FWD;
                    n_state    = S_IDLE;
                end else begin
                    o_ctl.op = OP_CPY_RD;
                    n_state  = S_YWR;
                end
            end
            S_YWR: begin
                o_ctl.op = OP_CPY_WR;
                n_state  = S_YRD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    `AST_NEXT(a_emit_idle, i_clk, i_rst_n, o_ctl.emit, r_state == S_IDLE)
    `AST_IMPL(a_accept_idle, i_clk, i_rst_n, o_ctl.op == OP_ACCEPT, !o_busy)
    `AST_IMPL(a_emit_busy, i_clk, i_rst_n, o_ctl.emit, o_busy)
endmodule

### hdl/ppdf_dp.sv
`timescale 1ns / 1ps
`include "per_path_delta_filter_assert.svh"
module ppdf_dp #(
    parameter int PATHS   = 16,
    parameter int MAX_LEN = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ppdf_pkg::t_ctl  i_ctl,
    output ppdf_pkg::t_sts  o_sts,
    input  logic            i_cfg_valid,
    input  logic [1:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_data,
    input  logic            i_req_type,
    input  logic [31:0]     i_path_key,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last_byte,
    input  logic [31:0]     i_now_ms,
    output logic            o_done,
    output logic            o_forward,
    output logic            o_version_due,
    output logic [1:0]      o_status,
    output logic [31:0]     o_forwarded_total,
    output logic [31:0]     o_filtered_total
);
    import ppdf_pkg::*;

    localparam int EW    = (PATHS > 1) ? $clog2(PATHS) : 1;
    localparam int FW    = $clog2(PATHS + 1);
    localparam int LW    = $clog2(MAX_LEN + 2);
    localparam int SW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DEPTH = PATHS * MAX_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [1:0]    r_cfg_tier;
    logic [15:0]   r_cfg_max;
    logic [7:0]    r_cfg_min;

    logic [31:0]   m_key  [PATHS];
    logic [15:0]   m_wc   [PATHS];
    logic [31:0]   m_ws   [PATHS];
    logic [LW-1:0] m_slen [PATHS];
    logic [7:0]    m_saved [DEPTH];
    logic [7:0]    m_stage [MAX_LEN];

    logic [PATHS-1:0] r_pend;
    logic [FW-1:0]    r_fill;
    logic [FW-1:0]    r_idx;
    logic [EW-1:0]    r_e;
    logic [LW-1:0]    r_inc, n_inc;
    logic [LW-1:0]    r_len, r_lo, r_i;
    logic [7:0]       r_diff;
    logic             r_is_q;
    logic [1:0]       r_tier;
    logic [31:0]      r_key, r_now;
    logic [31:0]      r_keyq, r_wsq;
    logic [15:0]      r_wcq;
    logic [LW-1:0]    r_slenq;
    logic [7:0]       r_svq, r_stq;
    logic [31:0]      r_fwd_cnt, r_flt_cnt;

    logic [AW-1:0]    w_saddr;
    logic [LW-1:0]    w_dabs, w_lo;
    logic [7:0]       w_dinit;
    logic [31:0]      w_elapsed;
    logic             w_rate_new, w_rate_ok;
    logic             w_acc;

    assign w_acc   = (i_ctl.op == OP_ACCEPT);
    assign w_saddr = AW'(r_e) * AW'(MAX_LEN) + AW'(r_i);
    assign n_inc   = (r_inc <= LW'(MAX_LEN)) ? r_inc + 1'b1 : r_inc;
    assign w_dabs  = (r_slenq > r_len) ? r_slenq - r_len : r_len - r_slenq;
    assign w_lo    = (r_slenq < r_len) ? r_slenq : r_len;
    assign w_dinit = (32'(w_dabs) > 32'd255) ? 8'hFF : 8'(w_dabs);
    assign w_elapsed  = r_now - r_wsq;
    assign w_rate_new = (r_wcq == 16'd0) || (w_elapsed >= WINDOW_MS);
    assign w_rate_ok  = w_rate_new || (r_wcq < r_cfg_max);

    always_comb begin
        o_sts.acc_end   = i_req_type | i_last_byte;
        o_sts.is_q      = r_is_q;
        o_sts.tier      = r_tier;
        o_sts.too_long  = (r_len > LW'(MAX_LEN));
        o_sts.idx_end   = (r_idx == r_fill);
        o_sts.full      = (r_fill == FW'(PATHS));
        o_sts.key_hit   = (r_keyq == r_key);
        o_sts.old_zero  = (r_slenq == '0);
        o_sts.cmp_end   = (r_i == r_lo);
        o_sts.thresh_ok = (r_diff >= r_cfg_min);
        o_sts.cpy_end   = (r_i == r_len);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_tier <= TIER_FULL;
            r_cfg_max  <= 16'd10;
            r_cfg_min  <= 8'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TIER: r_cfg_tier <= i_cfg_data[1:0];
                CFG_MAXU: r_cfg_max  <= i_cfg_data;
                CFG_MINC: r_cfg_min  <= i_cfg_data[7:0];
                default:  ;
            endcase
        end
    end

    // staging buffer
    always_ff @(posedge i_clk) begin
        if (w_acc && !i_req_type && r_inc < LW'(MAX_LEN)) begin
            m_stage[r_inc[SW-1:0]] <= i_data_byte;
        end
        if (i_ctl.op == OP_CMP_RD || i_ctl.op == OP_CPY_RD) begin
            r_stq <= m_stage[r_i[SW-1:0]];
        end
    end

    // saved deltas
    always_ff @(posedge i_clk) begin
        if (i_ctl.op == OP_CPY_WR) begin
            m_saved[w_saddr] <= r_stq;
        end
        if (i_ctl.op == OP_CMP_RD) begin
            r_svq <= m_saved[w_saddr];
        end
    end

    // path table
    always_ff @(posedge i_clk) begin
        if (i_ctl.op == OP_ALLOC) begin
            m_key[r_fill[EW-1:0]]  <= r_key;
            m_wc[r_fill[EW-1:0]]   <= 16'd0;
            m_ws[r_fill[EW-1:0]]   <= 32'd0;
            m_slen[r_fill[EW-1:0]] <= '0;
        end
        if (i_ctl.op == OP_RATE) begin
            if (w_rate_new) begin
                m_ws[r_e] <= r_now;
                m_wc[r_e] <= 16'd1;
            end else if (w_rate_ok) begin
                m_wc[r_e] <= r_wcq + 16'd1;
            end
        end
        if (i_ctl.op == OP_SAVE_LEN) begin
            m_slen[r_e] <= r_len;
        end
        if (i_ctl.op == OP_SRCH_RD) begin
            r_keyq <= m_key[r_idx[EW-1:0]];
        end
        if (i_ctl.op == OP_ENT_RD) begin
            r_wcq   <= m_wc[r_e];
            r_wsq   <= m_ws[r_e];
            r_slenq <= m_slen[r_e];
        end
    end

    // sequencing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_pend <= '0;
            r_inc  <= '0;
            r_idx  <= '0;
        end else begin
            case (i_ctl.op)
                OP_ACCEPT: begin
                    r_idx <= '0;
                    if (i_req_type) begin
                        r_is_q <= 1'b1;
                        r_key  <= i_path_key;
                        r_tier <= r_cfg_tier;
                    end else if (i_last_byte) begin
                        r_is_q <= 1'b0;
                        r_key  <= i_path_key;
                        r_now  <= i_now_ms;
                        r_tier <= r_cfg_tier;
                        r_len  <= n_inc;
                        r_inc  <= '0;
                    end else begin
                        r_inc <= n_inc;
                    end
                end
                OP_SRCH_NEXT: r_idx <= r_idx + 1'b1;
                OP_HIT:       r_e   <= r_idx[EW-1:0];
                OP_ALLOC: begin
                    r_e                   <= r_fill[EW-1:0];
                    r_pend[r_fill[EW-1:0]] <= 1'b0;
                    r_fill                <= r_fill + 1'b1;
                end
                OP_SET_PEND: r_pend[r_e] <= 1'b1;
                OP_QCLR:     r_pend[r_e] <= 1'b0;
                OP_CMP_INIT: begin
                    r_i    <= '0;
                    r_lo   <= w_lo;
                    r_diff <= w_dinit;
                end
                OP_CMP_STEP: begin
                    if (r_svq != r_stq && r_diff != 8'hFF) r_diff <= r_diff + 8'd1;
                    r_i <= r_i + 1'b1;
                end
                OP_CPY_INIT: r_i <= '0;
                OP_CPY_WR:   r_i <= r_i + 1'b1;
                default: ;
            endcase
        end
    end

    // result register and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done        <= 1'b0;
            o_forward     <= 1'b0;
            o_version_due <= 1'b0;
            o_status      <= ST_OK;
            r_fwd_cnt     <= '0;
            r_flt_cnt     <= '0;
        end else begin
            o_done <= i_ctl.emit;
            if (i_ctl.emit) begin
                o_forward     <= 1'b0;
                o_version_due <= 1'b0;
                o_status      <= ST_OK;
                case (i_ctl.res)
                    RES_FWD: begin
                        o_forward <= 1'b1;
                        r_fwd_cnt <= r_fwd_cnt + 32'd1;
                    end
                    RES_DROP: r_flt_cnt <= r_flt_cnt + 32'd1;
                    RES_FULL: begin
                        o_status  <= ST_FULL;
                        r_flt_cnt <= r_flt_cnt + 32'd1;
                    end
                    RES_LONG: begin
                        o_status  <= ST_LONG;
                        r_flt_cnt <= r_flt_cnt + 32'd1;
                    end
                    RES_QUERY: o_version_due <= r_pend[r_e];
                    RES_RATE: begin
                        o_forward <= w_rate_ok;
                        if (w_rate_ok) r_fwd_cnt <= r_fwd_cnt + 32'd1;
                        else           r_flt_cnt <= r_flt_cnt + 32'd1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_forwarded_total = r_fwd_cnt;
    assign o_filtered_total  = r_flt_cnt;

    `AST_NEVER(a_fill_range, i_clk, i_rst_n, r_fill > FW'(PATHS))
    `AST_IMPL(a_fwd_ok, i_clk, i_rst_n, o_done && o_forward, o_status == ST_OK && !o_version_due)
    `AST_IMPL(a_cmp_bound, i_clk, i_rst_n, i_ctl.op == OP_CMP_RD, r_i < r_lo)
    `AST_IMPL(a_cpy_bound, i_clk, i_rst_n, i_ctl.op == OP_CPY_WR, r_i < LW'(MAX_LEN))
endmodule

### hdl/per_path_delta_filter.sv
`timescale 1ns / 1ps
// Sequencing: a full-tier last byte, a too-long delta or a query outside metadata tier
// gets its verdict in the decide state; other items search the table entry by entry,
// taking a new entry on a miss, then in change tier compare and save deltas byte by byte.
// Non-final delta bytes are taken while idle; a new item waits until the block is idle.
// Results cannot be stalled. Synchronous active-low reset empties the table.
module per_path_delta_filter #(
    parameter int PATHS   = 16,
    parameter int MAX_LEN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_req_type,
    input  logic [31:0] i_path_key,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [31:0] i_now_ms,
    output logic        o_done,
    output logic        o_forward,
    output logic        o_version_due,
    output logic [1:0]  o_status,
    output logic [31:0] o_forwarded_total,
    output logic [31:0] o_filtered_total,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import ppdf_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    ppdf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .o_busy  (o_busy)
    );

    ppdf_dp #(
        .PATHS   (PATHS),
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_ctl),
        .o_sts             (w_sts),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_req_type        (i_req_type),
        .i_path_key        (i_path_key),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .i_now_ms          (i_now_ms),
        .o_done            (o_done),
        .o_forward         (o_forward),
        .o_version_due     (o_version_due),
        .o_status          (o_status),
        .o_forwarded_total (o_forwarded_total),
        .o_filtered_total  (o_filtered_total)
    );
endmodule

### sim/tb.sv
`timescale 1ns / 1ps
module tb;
    import ppdf_pkg::*;

    localparam int NPATH   = 16;
    localparam int MAXLEN  = 64;
    localparam int NKEYS   = 24;
    localparam int WDOG    = 20000;

    typedef struct packed {
        logic        forward;
        logic        version_due;
        logic [1:0]  status;
        logic [31:0] fwd_total;
        logic [31:0] flt_total;
    } t_verdict;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [15:0] val;
        logic        req;
        logic [31:0] key;
        logic [7:0]  dbyte;
        int          nbytes;
        logic        last;
        logic [31:0] now;
        bit          typed;
        t_verdict    res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_req_type;
    logic [31:0] i_path_key;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic [31:0] i_now_ms;
    logic        o_done;
    logic        o_forward;
    logic        o_version_due;
    logic [1:0]  o_status;
    logic [31:0] o_forwarded_total;
    logic [31:0] o_filtered_total;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    per_path_delta_filter dut (.*);

    // filter model state
    logic [1:0]  m_tier;
    logic [15:0] m_max_upd;
    logic [7:0]  m_min_chg;
    bit          m_used [NPATH];
    logic [31:0] m_key [NPATH];
    int          m_wcount [NPATH];
    logic [31:0] m_wstart [NPATH];
    bit          m_pend [NPATH];
    int          m_slen [NPATH];
    logic [7:0]  m_saved [NPATH][MAXLEN];
    logic [7:0]  m_stage [MAXLEN];
    int          m_inlen;
    logic [31:0] m_fwd_cnt;
    logic [31:0] m_flt_cnt;

    t_verdict    verdict_q[$];
    t_row        rows[$];
    logic [31:0] key_pool [NKEYS];
    int          idle_pct;
    int          errors;
    int          n_items;
    int          n_verdicts;
    int          quiet;
    logic [31:0] clock_ms;

    function automatic int lookup_path(logic [31:0] key);
        for (int e = 0; e < NPATH; e++)
            if (m_used[e] && m_key[e] == key) return e;
        return -1;
    endfunction

    function automatic int claim_path(logic [31:0] key);
        int e;
        e = lookup_path(key);
        if (e >= 0) return e;
        for (int f = 0; f < NPATH; f++) begin
            if (!m_used[f]) begin
                m_used[f] = 1; m_key[f] = key; m_wcount[f] = 0; m_wstart[f] = '0;
                m_pend[f] = 0; m_slen[f] = 0;
                return f;
            end
        end
        return -1;
    endfunction

    function automatic bit filter_item(logic req, logic [31:0] key, logic [7:0] dbyte,
                                       logic last, logic [31:0] now, output t_verdict v);
        int e, len, lo, diff;
        logic [31:0] age;
        v = '0;
        if (req) begin
            if (m_tier == TIER_META) begin
                e = lookup_path(key);
                if (e >= 0 && m_pend[e]) begin
                    m_pend[e] = 0; v.version_due = 1;
                end
            end
        end else begin
            if (m_inlen < MAXLEN) m_stage[m_inlen] = dbyte;
            if (m_inlen <= MAXLEN) m_inlen++;
            if (!last) return 0;
            len = m_inlen;
            m_inlen = 0;
            if (m_tier == TIER_FULL) begin
                v.forward = 1;
            end else if (m_tier == TIER_CHG && len > MAXLEN) begin
                v.status = ST_LONG;
            end else begin
                e = claim_path(key);
                if (e < 0) begin
                    v.status = ST_FULL;
                end else if (m_tier == TIER_RATE) begin
                    age = now - m_wstart[e];
                    if (m_wcount[e] == 0 || age >= 32'd1000) begin
                        m_wstart[e] = now; m_wcount[e] = 1; v.forward = 1;
                    end else if (m_wcount[e] < m_max_upd) begin
                        m_wcount[e] = (m_wcount[e] + 1) & 16'hFFFF; v.forward = 1;
                    end
                end else if (m_tier == TIER_CHG) begin
                    if (m_slen[e] == 0) begin
                        v.forward = 1;
                    end else begin
                        lo = m_slen[e] < len ? m_slen[e] : len;
                        diff = m_slen[e] > len ? m_slen[e] - len : len - m_slen[e];
                        for (int i = 0; i < lo; i++)
                            if (m_saved[e][i] != m_stage[i] && diff < 255) diff++;
                        if (diff > 255) diff = 255;
                        v.forward = diff >= m_min_chg;
                    end
                    if (v.forward) begin
                        for (int i = 0; i < len; i++) m_saved[e][i] = m_stage[i];
                        m_slen[e] = len;
                    end
                end else begin
                    m_pend[e] = 1;
                end
            end
            if (v.forward) m_fwd_cnt++;
            else m_flt_cnt++;
        end
        v.fwd_total = m_fwd_cnt;
        v.flt_total = m_flt_cnt;
        return 1;
    endfunction

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_verdict x;
        if (i_rst_n && o_done) begin
            n_verdicts++;
            if (verdict_q.size() == 0) begin
                $error("verdict with none expected");
                errors++;
            end else begin
                x = verdict_q.pop_front();
                if (o_forward !== x.forward) begin
                    $error("forward exp %0d got %0d", x.forward, o_forward); errors++;
                end
                if (o_version_due !== x.version_due) begin
                    $error("version_due exp %0d got %0d", x.version_due, o_version_due);
                    errors++;
                end
                if (o_status !== x.status) begin
                    $error("status exp %0d got %0d", x.status, o_status); errors++;
                end
                if (o_forwarded_total !== x.fwd_total) begin
                    $error("forwarded_total exp %0d got %0d", x.fwd_total,
                           o_forwarded_total);
                    errors++;
                end
                if (o_filtered_total !== x.flt_total) begin
                    $error("filtered_total exp %0d got %0d", x.flt_total,
                           o_filtered_total);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WDOG) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic send(logic req, logic [31:0] key, logic [7:0] dbyte, logic last,
                        logic [31:0] now, bit typed, t_verdict tv);
        t_verdict v;
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 0;
            @(posedge i_clk);
        end
        i_start     <= 1;
        i_req_type  <= req;
        i_path_key  <= key;
        i_data_byte <= dbyte;
        i_last_byte <= last;
        i_now_ms    <= now;
        do @(posedge i_clk); while (o_busy);
        n_items++;
        if (filter_item(req, key, dbyte, last, now, v))
            verdict_q.push_back(typed ? tv : v);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_start <= 0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        case (idx)
            CFG_TIER: m_tier    = val[1:0];
            CFG_MAXU: m_max_upd = val;
            CFG_MINC: m_min_chg = val[7:0];
            default: ;
        endcase
    endtask

    function automatic void add_cfg(logic [1:0] idx, logic [15:0] val);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1; r.idx = idx; r.val = val;
        rows.push_back(r);
    endfunction

    function automatic void add_item(logic req, logic [31:0] key, logic [7:0] dbyte,
                                     int nbytes, logic last, logic [31:0] now,
                                     bit typed, t_verdict res);
        t_row r;
        r = '{default: '0};
        r.req = req; r.key = key; r.dbyte = dbyte; r.nbytes = nbytes; r.last = last;
        r.now = now; r.typed = typed; r.res = res;
        rows.push_back(r);
    endfunction

    function automatic logic [31:0] pick_key();
        if ($urandom_range(9) == 0) return $urandom;
        return key_pool[$urandom_range(NKEYS - 1)];
    endfunction

    initial begin
        t_verdict nv;
        int n, len, ph;
        logic [31:0] k;
        errors = 0; n_items = 0; n_verdicts = 0; quiet = 0; idle_pct = 0;
        clock_ms = '0;
        i_rst_n = 0; i_start = 0; i_req_type = 0; i_path_key = '0; i_data_byte = '0;
        i_last_byte = 0; i_now_ms = '0; i_cfg_valid = 0; i_cfg_index = '0; i_cfg_data = '0;
        m_tier = TIER_FULL; m_max_upd = 16'd10; m_min_chg = 8'd1;
        m_inlen = 0; m_fwd_cnt = '0; m_flt_cnt = '0;
        for (int e = 0; e < NPATH; e++) begin
            m_used[e] = 0; m_wcount[e] = 0; m_pend[e] = 0; m_slen[e] = 0;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < NKEYS; i++) key_pool[i] = $urandom;

        nv = '0;
        add_item(0, '1, 8'hFF, 1, 1, '0, 1, '{1'b1, 1'b0, ST_OK, 32'd1, 32'd0});
        add_item(1, '1, 8'h00, 1, 1, '0, 1, '{1'b0, 1'b0, ST_OK, 32'd1, 32'd0});
        add_cfg(CFG_TIER, 16'(TIER_META));
        add_item(0, '1, 8'h00, 1, 1, '0, 1, '{1'b0, 1'b0, ST_OK, 32'd1, 32'd1});
        add_item(1, '1, 8'h00, 1, 1, '0, 1, '{1'b0, 1'b1, ST_OK, 32'd1, 32'd1});
        add_item(1, '1, 8'h00, 1, 1, '0, 0, nv);
        add_item(1, '0, 8'h00, 1, 1, '0, 1, '{1'b0, 1'b0, ST_OK, 32'd1, 32'd1});
        add_cfg(CFG_TIER, 16'(TIER_RATE));
        add_cfg(CFG_MAXU, 16'd0);
        // zero limit, then window expiry across time wrap
        add_item(0, '1, 8'h12, 1, 1, 32'hFFFF_FF00, 0, nv);
        add_item(0, '1, 8'h12, 1, 1, 32'hFFFF_FF10, 0, nv);
        add_item(0, '1, 8'h12, 1, 1, 32'h0000_02F0, 0, nv);
        add_cfg(CFG_MAXU, 16'hFFFF);
        add_cfg(CFG_TIER, 16'(TIER_CHG));
        add_cfg(CFG_MINC, 16'd2);
        add_item(0, '1, 8'hAA, 2, 1, '0, 0, nv);
        add_item(0, '1, 8'hAA, 2, 1, '0, 0, nv);
        add_item(0, '1, 8'h00, 65, 1, '0, 1, '{1'b0, 1'b0, ST_LONG, 32'd4, 32'd4});
        add_item(0, '1, 8'h55, 3, 1, '0, 0, nv);
        // query in the middle of a delta
        add_item(0, 32'd1, 8'h11, 1, 0, '0, 0, nv);
        add_item(1, '1, 8'h00, 1, 1, '0, 0, nv);
        add_item(0, 32'd1, 8'h22, 1, 1, '0, 0, nv);
        add_cfg(CFG_MINC, 16'd255);
        add_item(0, '1, 8'h00, 3, 1, '0, 0, nv);
        add_cfg(CFG_MINC, 16'd0);
        add_item(0, '1, 8'h00, 3, 1, '0, 0, nv);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].is_cfg)
                write_reg(rows[r].idx, rows[r].val);
            else
                for (int b = 0; b < rows[r].nbytes; b++)
                    send(rows[r].req, rows[r].key, rows[r].dbyte,
                         rows[r].last && b == rows[r].nbytes - 1, rows[r].now,
                         rows[r].typed && b == rows[r].nbytes - 1, rows[r].res);
        end

        for (ph = 0; ph < 8; ph++) begin
            write_reg(CFG_TIER, 16'(ph % 4));
            case (ph % 3)
                0: write_reg(CFG_MAXU, 16'd0);
                1: write_reg(CFG_MAXU, 16'hFFFF);
                default: write_reg(CFG_MAXU, 16'($urandom_range(1, 5)));
            endcase
            case (ph % 4)
                0: write_reg(CFG_MINC, 16'd255);
                1: write_reg(CFG_MINC, 16'd0);
                default: write_reg(CFG_MINC, 16'($urandom_range(1, 4)));
            endcase
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 54;
                2: idle_pct = 0;
                default: idle_pct = 33;
            endcase
            n = 0;
            while (n < 50) begin
                clock_ms = ($urandom_range(29) == 0) ? $urandom
                                                     : clock_ms + $urandom_range(0, 400);
                k = pick_key();
                if ($urandom_range(99) < 15) begin
                    send(1, k, 8'($urandom), 1'($urandom), clock_ms, 0, nv);
                    n++;
                end else begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(50, 70)
                                                   : $urandom_range(1, 6);
                    for (int b = 0; b < len; b++) begin
                        if ($urandom_range(19) == 0) begin
                            send(1, pick_key(), 8'($urandom), 1'($urandom), clock_ms, 0, nv);
                            n++;
                        end
                        if ($urandom_range(19) == 0)
                            send(0, $urandom, 8'($urandom), 0, $urandom, 0, nv);
                        else
                            send(0, k,
                                 8'($urandom_range(1) ? $urandom_range(0, 3) : $urandom),
                                 b == len - 1, clock_ms, 0, nv);
                        n++;
                    end
                end
            end
        end

        i_start <= 0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("tb: %0d items sent over all four tiers, %0d verdicts checked",
                 n_items, n_verdicts);
        $display("tb: register extremes, rate windows, change thresholds, full table");
        if (errors == 0 && verdict_q.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
